FILE: sv/rhh_pkg.sv
`default_nettype none
package rhh_pkg;

  localparam int SLOTS_DEF = 1024;
  localparam int CAP_W     = 11;
  localparam int KEY_W     = 31;
  localparam int PROBE_W   = 11;
  localparam int REQ_W     = 2;
  localparam int SLOT_W    = KEY_W + 2;
  localparam int OCC_BIT   = KEY_W + 1;
  localparam int TOMB_BIT  = KEY_W;
  localparam int MCNT_W    = $clog2(KEY_W);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_RD,
    ST_EV,
    ST_RMOD,
    ST_RCHK,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: sv/rhh_req_if.sv
`default_nettype none
interface rhh_req_if;
  logic                      valid;
  logic                      ready;
  logic [rhh_pkg::REQ_W-1:0] req_type;
  logic [rhh_pkg::KEY_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface
`default_nettype wire

FILE: sv/rhh_res_if.sv
`default_nettype none
interface rhh_res_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic                        full_res;
  logic [rhh_pkg::PROBE_W-1:0] probes;

  modport source (output valid, output hit, output full_res, output probes, input ready);
  modport sink (input valid, input hit, input full_res, input probes, output ready);
endinterface
`default_nettype wire

FILE: sv/robin_hood_hash_table.sv
// a request finds its home slot bit-serially as key mod capacity, then reads and evaluates
//   each probed slot; for an occupied slot whose resident distance is needed, that resident's
//   home is found bit-serially in turn; the result is then registered
// one request at a time; the next is taken once the result is registered
// reset: sync active-low; a clearing pass writes every slot empty, with no request
//   taken meanwhile; capacity register returns to 1024
`default_nettype none
module robin_hood_hash_table #(
  parameter int SLOTS = rhh_pkg::SLOTS_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  rhh_req_if.sink                     in_req,
  rhh_res_if.source                   out_res,
  input  wire                         cfg_we,
  input  wire [rhh_pkg::CAP_W-1:0]    cfg_wdata
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);
  localparam int PW = CW + 1;
  localparam int KW = rhh_pkg::KEY_W;
  localparam int SW = rhh_pkg::SLOT_W;
  localparam int MW = rhh_pkg::MCNT_W;

  logic [SW-1:0] slot_mem [SLOTS];
  logic [SW-1:0] rdata_r;

  rhh_pkg::state_t state_r, state_nxt;
  rhh_pkg::req_t   req_r, req_nxt;
  logic [rhh_pkg::CAP_W-1:0] cfg_cap_r;
  logic [KW-1:0] key_r, key_nxt, carry_r, carry_nxt, mkey_r, mkey_nxt;
  logic [CW-1:0] cdist_r, cdist_nxt, iter_r, iter_nxt, mrem_r, mrem_nxt;
  logic [IW-1:0] idx_r, idx_nxt, clr_r, clr_nxt;
  logic [MW-1:0] mcnt_r, mcnt_nxt;
  logic [PW-1:0] probes_r, probes_nxt;
  logic          hit_r, hit_nxt, full_r, full_nxt, cnt_only_r, cnt_only_nxt;
  logic          out_valid_r, out_valid_nxt, out_hit_r, out_hit_nxt;
  logic          out_full_r, out_full_nxt;
  logic [PW-1:0] out_probes_r, out_probes_nxt;

  logic [CW-1:0] cap, res_dist, idx_e, idx_e1, cdist_base;
  logic [CW:0]   mod_t, mod_r;
  logic [IW-1:0] idx_next;
  logic          occ, tomb, last, mod_last;
  logic [KW-1:0] rkey;
  logic          ev_fin, ev_mod, ev_adv, ev_hit, ev_wr, ev_swap;
  logic [SW-1:0] ev_wdata;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;
  logic          in_xfer;

  // effective capacity: zero acts as one, above SLOTS acts as SLOTS
  always_comb begin
    if (cfg_cap_r == '0) begin
      cap = CW'(1);
    end else if (32'(cfg_cap_r) > 32'(SLOTS)) begin
      cap = CW'(SLOTS);
    end else begin
      cap = CW'(cfg_cap_r);
    end
  end

  assign occ      = rdata_r[rhh_pkg::OCC_BIT];
  assign tomb     = rdata_r[rhh_pkg::TOMB_BIT];
  assign rkey     = rdata_r[KW-1:0];
  assign idx_e    = CW'(idx_r);
  assign idx_e1   = idx_e + CW'(1);
  assign idx_next = (idx_e1 >= cap) ? '0 : idx_e1[IW-1:0];
  assign res_dist = (idx_e >= mrem_r) ? idx_e - mrem_r : idx_e + cap - mrem_r;
  assign last     = (iter_r + CW'(1)) == cap;
  assign in_xfer  = in_req.valid && in_req.ready;

  // one restoring step of key mod capacity
  assign mod_t    = {mrem_r, mkey_r[KW-1]};
  assign mod_r    = (mod_t >= {1'b0, cap}) ? mod_t - {1'b0, cap} : mod_t;
  assign mod_last = mcnt_r == MW'(KW - 1);

  // per-slot decision
  always_comb begin
    ev_fin   = 1'b0;
    ev_mod   = 1'b0;
    ev_adv   = 1'b0;
    ev_hit   = 1'b0;
    ev_wr    = 1'b0;
    ev_swap  = 1'b0;
    ev_wdata = '0;
    case (state_r)
      rhh_pkg::ST_EV: begin
        case (req_r)
          rhh_pkg::REQ_INSERT: begin
            if (!occ) begin
              ev_fin = 1'b1;
              if (!cnt_only_r) begin
                ev_wr    = 1'b1;
                ev_wdata = {1'b1, 1'b0, carry_r};
              end
            end else if (cnt_only_r) begin
              ev_adv = 1'b1;
            end else if (rkey == carry_r) begin
              ev_hit = 1'b1;
              ev_adv = 1'b1;
            end else begin
              ev_mod = 1'b1;
            end
          end
          rhh_pkg::REQ_SEARCH: begin
            if (!occ && !tomb) begin
              ev_fin = 1'b1;
            end else if (occ && rkey == key_r) begin
              ev_hit = 1'b1;
              ev_fin = 1'b1;
            end else if (occ) begin
              ev_mod = 1'b1;
            end else begin
              ev_adv = 1'b1;
            end
          end
          rhh_pkg::REQ_REMOVE: begin
            if (!occ && !tomb) begin
              ev_fin = 1'b1;
            end else if (occ && rkey == key_r) begin
              ev_hit   = 1'b1;
              ev_fin   = 1'b1;
              ev_wr    = 1'b1;
              ev_wdata = {1'b0, 1'b1, {KW{1'b0}}};
            end else begin
              ev_adv = 1'b1;
            end
          end
          default: ev_fin = 1'b1;
        endcase
      end
      rhh_pkg::ST_RCHK: begin
        if (req_r == rhh_pkg::REQ_SEARCH) begin
          if (iter_r > res_dist) begin
            ev_fin = 1'b1;
          end else begin
            ev_adv = 1'b1;
          end
        end else begin
          ev_adv = 1'b1;
          if (cdist_r > res_dist) begin
            ev_swap  = 1'b1;
            ev_wr    = 1'b1;
            ev_wdata = {1'b1, 1'b0, carry_r};
          end
        end
      end
      default: ;
    endcase
  end

  assign cdist_base = ev_swap ? res_dist : cdist_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rhh_pkg::ST_CLEAR: if (clr_r == IW'(SLOTS - 1)) state_nxt = rhh_pkg::ST_IDLE;
      rhh_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_req.req_type == rhh_pkg::REQ_NONE) ? rhh_pkg::ST_DONE
                                                            : rhh_pkg::ST_HOME;
        end
      end
      rhh_pkg::ST_HOME: if (mod_last) state_nxt = rhh_pkg::ST_RD;
      rhh_pkg::ST_RD:   state_nxt = rhh_pkg::ST_EV;
      rhh_pkg::ST_EV, rhh_pkg::ST_RCHK: begin
        if (ev_fin || (ev_adv && last)) begin
          state_nxt = rhh_pkg::ST_DONE;
        end else if (ev_mod) begin
          state_nxt = rhh_pkg::ST_RMOD;
        end else begin
          state_nxt = rhh_pkg::ST_RD;
        end
      end
      rhh_pkg::ST_RMOD: if (mod_last) state_nxt = rhh_pkg::ST_RCHK;
      rhh_pkg::ST_DONE: if (!out_valid_r || out_res.ready) state_nxt = rhh_pkg::ST_IDLE;
      default: state_nxt = rhh_pkg::ST_CLEAR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    req_nxt        = req_r;
    key_nxt        = key_r;
    carry_nxt      = carry_r;
    mkey_nxt       = mkey_r;
    mrem_nxt       = mrem_r;
    mcnt_nxt       = mcnt_r;
    cdist_nxt      = cdist_r;
    iter_nxt       = iter_r;
    idx_nxt        = idx_r;
    clr_nxt        = clr_r;
    probes_nxt     = probes_r;
    hit_nxt        = hit_r;
    full_nxt       = full_r;
    cnt_only_nxt   = cnt_only_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_hit_nxt    = out_hit_r;
    out_full_nxt   = out_full_r;
    out_probes_nxt = out_probes_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = ev_wdata;
    case (state_r)
      rhh_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + IW'(1);
      end
      rhh_pkg::ST_IDLE: begin
        if (in_xfer) begin
          req_nxt      = rhh_pkg::req_t'(in_req.req_type);
          key_nxt      = in_req.key;
          carry_nxt    = in_req.key;
          mkey_nxt     = in_req.key;
          mrem_nxt     = '0;
          mcnt_nxt     = '0;
          cdist_nxt    = '0;
          iter_nxt     = '0;
          probes_nxt   = '0;
          hit_nxt      = 1'b0;
          full_nxt     = 1'b0;
          cnt_only_nxt = 1'b0;
        end
      end
      rhh_pkg::ST_HOME, rhh_pkg::ST_RMOD: begin
        mrem_nxt = mod_r[CW-1:0];
        mkey_nxt = {mkey_r[KW-2:0], 1'b0};
        mcnt_nxt = mcnt_r + MW'(1);
        if (mod_last && state_r == rhh_pkg::ST_HOME) idx_nxt = mod_r[IW-1:0];
      end
      rhh_pkg::ST_EV, rhh_pkg::ST_RCHK: begin
        mem_we = ev_wr;
        if (ev_hit) begin
          hit_nxt      = 1'b1;
          cnt_only_nxt = 1'b1;
        end
        if (ev_swap) carry_nxt = rkey;
        if (ev_mod) begin
          mkey_nxt = rkey;
          mrem_nxt = '0;
          mcnt_nxt = '0;
        end
        if (ev_fin) begin
          probes_nxt = (req_r == rhh_pkg::REQ_REMOVE || req_r == rhh_pkg::REQ_NONE)
                       ? '0 : PW'(iter_r) + PW'(1);
        end else if (ev_adv) begin
          if (last) begin
            // every slot in use was visited
            probes_nxt = (req_r == rhh_pkg::REQ_REMOVE) ? '0 : PW'(cap) + PW'(1);
            full_nxt   = req_r == rhh_pkg::REQ_INSERT && !hit_r && !ev_hit;
          end else begin
            idx_nxt   = idx_next;
            iter_nxt  = iter_r + CW'(1);
            cdist_nxt = cdist_base + CW'(1);
          end
        end
      end
      rhh_pkg::ST_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = hit_r;
          out_full_nxt   = full_r;
          out_probes_nxt = probes_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
    if (state_r == rhh_pkg::ST_RD) rdata_r <= slot_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rhh_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_cap_r   <= rhh_pkg::CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) cfg_cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    carry_r      <= carry_nxt;
    mkey_r       <= mkey_nxt;
    mrem_r       <= mrem_nxt;
    mcnt_r       <= mcnt_nxt;
    cdist_r      <= cdist_nxt;
    iter_r       <= iter_nxt;
    idx_r        <= idx_nxt;
    probes_r     <= probes_nxt;
    hit_r        <= hit_nxt;
    full_r       <= full_nxt;
    cnt_only_r   <= cnt_only_nxt;
    out_hit_r    <= out_hit_nxt;
    out_full_r   <= out_full_nxt;
    out_probes_r <= out_probes_nxt;
  end

  assign in_req.ready     = state_r == rhh_pkg::ST_IDLE;
  assign out_res.valid    = out_valid_r;
  assign out_res.hit      = out_hit_r;
  assign out_res.full_res = out_full_r;
  assign out_res.probes   = rhh_pkg::PROBE_W'(out_probes_r);

endmodule
`default_nettype wire

FILE: verif/tb_robin_hood_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_robin_hood_hash_table;

  localparam int SLOTS = rhh_pkg::SLOTS_DEF;
  localparam int QUIET_LIMIT = 400000;

  typedef struct packed {
    logic                        hit;
    logic                        full_res;
    logic [rhh_pkg::PROBE_W-1:0] probes;
  } lookup_result_t;

  class hash_set_tracker;
    logic                      occ [SLOTS];
    logic                      tomb [SLOTS];
    int unsigned               keys [SLOTS];
    logic [rhh_pkg::CAP_W-1:0] cap_reg;
    lookup_result_t            pending [$];
    int                        errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        occ[i] = 0;
        tomb[i] = 0;
        keys[i] = 0;
      end
      cap_reg = rhh_pkg::CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [rhh_pkg::CAP_W-1:0] v);
      cap_reg = v;
    endfunction

    function int unsigned live_cap();
      int unsigned c;
      c = 32'(cap_reg);
      if (c == 0) c = 1;
      if (c > SLOTS) c = SLOTS;
      return c;
    endfunction

    function int unsigned home_dist(int unsigned idx, int unsigned k, int unsigned cap);
      int unsigned home;
      home = k % cap;
      return (idx >= home) ? idx - home : idx + cap - home;
    endfunction

    function int unsigned step(int unsigned idx, int unsigned cap);
      return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    // accepted request: update the tracked table and queue the expected result
    function void note_request(rhh_pkg::req_t req, logic [rhh_pkg::KEY_W-1:0] key_in);
      int unsigned cap, idx, k, carry, cdist, rdist, n, d, r;
      bit done;
      lookup_result_t e;
      e = '0;
      k = 32'(key_in);
      cap = live_cap();
      idx = k % cap;
      done = 0;
      case (req)
        rhh_pkg::REQ_INSERT: begin
          // probe count is taken on the table as it was before the insert
          n = 1;
          r = idx;
          for (int i = 0; i < cap; i++) begin
            if (!occ[r]) break;
            r = step(r, cap);
            n++;
          end
          e.probes = n[rhh_pkg::PROBE_W-1:0];
          carry = k;
          cdist = 0;
          for (int i = 0; i < cap && !done; i++) begin
            if (!occ[idx]) begin
              occ[idx] = 1;
              tomb[idx] = 0;
              keys[idx] = carry;
              done = 1;
            end else if (keys[idx] == carry) begin
              e.hit = 1;
              done = 1;
            end else begin
              rdist = home_dist(idx, keys[idx], cap);
              if (cdist > rdist) begin
                r = keys[idx];
                keys[idx] = carry;
                carry = r;
                cdist = rdist;
              end
              idx = step(idx, cap);
              cdist++;
            end
          end
          if (!done) e.full_res = 1;
        end
        rhh_pkg::REQ_SEARCH: begin
          d = 0;
          n = 1;
          for (int i = 0; i < cap && !done; i++) begin
            if (!occ[idx] && !tomb[idx]) done = 1;
            else if (occ[idx] && keys[idx] == k) begin
              e.hit = 1;
              done = 1;
            end else if (occ[idx] && d > home_dist(idx, keys[idx], cap)) done = 1;
            else begin
              idx = step(idx, cap);
              d++;
              n++;
            end
          end
          e.probes = n[rhh_pkg::PROBE_W-1:0];
        end
        rhh_pkg::REQ_REMOVE: begin
          for (int i = 0; i < cap && !done; i++) begin
            if (!occ[idx] && !tomb[idx]) done = 1;
            else if (occ[idx] && keys[idx] == k) begin
              occ[idx] = 0;
              tomb[idx] = 1;
              keys[idx] = 0;
              e.hit = 1;
              done = 1;
            end else idx = step(idx, cap);
          end
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(lookup_result_t got);
      lookup_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0d full=%0d probes=%0d",
                 $time, got.hit, got.full_res, got.probes);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, e.hit, got.hit);
        errors++;
      end
      if (got.full_res !== e.full_res) begin
        $display("%0t: full_res expected %0d actual %0d", $time, e.full_res, got.full_res);
        errors++;
      end
      if (got.probes !== e.probes) begin
        $display("%0t: probes expected %0d actual %0d", $time, e.probes, got.probes);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [rhh_pkg::CAP_W-1:0] cfg_wdata;
  int                        send_idle_pct;
  int                        stall_pct;
  int                        quiet_cycles;
  int unsigned               pool [$];
  hash_set_tracker           tracker;

  rhh_req_if req_ch ();
  rhh_res_if res_ch ();

  robin_hood_hash_table #(.SLOTS(SLOTS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // result side: check each transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready)
      tracker.check_result({res_ch.hit, res_ch.full_res, res_ch.probes});
    res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_request(rhh_pkg::req_t req, logic [rhh_pkg::KEY_W-1:0] key);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= req;
    req_ch.key <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.note_request(req, key);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_capacity(logic [rhh_pkg::CAP_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_capacity(v);
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 82; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 82; end
      default: begin send_idle_pct = 15; stall_pct = 15; end
    endcase
  endtask

  task automatic run_random(int count, int pool_size);
    int r;
    rhh_pkg::req_t req;
    logic [rhh_pkg::KEY_W-1:0] key;
    pool.delete();
    for (int i = 0; i < pool_size; i++) pool.push_back($urandom() & 32'h7fff_ffff);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) req = rhh_pkg::REQ_INSERT;
      else if (r < 75) req = rhh_pkg::REQ_SEARCH;
      else if (r < 95) req = rhh_pkg::REQ_REMOVE;
      else req = rhh_pkg::REQ_NONE;
      if ($urandom_range(0, 99) < 85)
        key = rhh_pkg::KEY_W'(pool[$urandom_range(0, pool.size() - 1)]);
      else key = rhh_pkg::KEY_W'($urandom());
      send_request(req, key);
    end
  endtask

  initial begin
    int caps [8] = '{0, 2, 5, 13, 64, 2047, 1024, 3};
    tracker = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = rhh_pkg::REQ_INSERT;
    req_ch.key = '0;
    res_ch.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes at reset capacity
    send_request(rhh_pkg::REQ_SEARCH, '0);
    send_request(rhh_pkg::REQ_INSERT, '0);
    send_request(rhh_pkg::REQ_INSERT, 31'h7fff_ffff);
    send_request(rhh_pkg::REQ_INSERT, '0);
    send_request(rhh_pkg::REQ_SEARCH, 31'h7fff_ffff);
    send_request(rhh_pkg::REQ_SEARCH, 31'd1024);
    send_request(rhh_pkg::REQ_NONE, 31'h7fff_ffff);
    send_request(rhh_pkg::REQ_REMOVE, '0);
    send_request(rhh_pkg::REQ_REMOVE, '0);
    // tombstone passed by search
    send_request(rhh_pkg::REQ_INSERT, 31'd2047);
    send_request(rhh_pkg::REQ_INSERT, 31'd3071);
    send_request(rhh_pkg::REQ_REMOVE, 31'd2047);
    send_request(rhh_pkg::REQ_SEARCH, 31'd3071);
    // small table: collisions, swaps, then full
    write_capacity(11'd4);
    send_request(rhh_pkg::REQ_INSERT, 31'd1);
    send_request(rhh_pkg::REQ_INSERT, 31'd5);
    send_request(rhh_pkg::REQ_INSERT, 31'd2);
    send_request(rhh_pkg::REQ_INSERT, 31'd9);
    send_request(rhh_pkg::REQ_INSERT, 31'd3);
    send_request(rhh_pkg::REQ_INSERT, 31'd8);
    send_request(rhh_pkg::REQ_SEARCH, 31'd2);
    send_request(rhh_pkg::REQ_SEARCH, 31'd12);
    send_request(rhh_pkg::REQ_REMOVE, 31'd5);
    send_request(rhh_pkg::REQ_INSERT, 31'd13);

    for (int p = 0; p < 8; p++) begin
      write_capacity(rhh_pkg::CAP_W'(caps[p]));
      set_idling(p);
      run_random(240, (caps[p] > 20) ? 48 : caps[p] * 2 + 3);
    end
    set_idling(3);
    write_capacity(11'd1024);
    run_random(40, 30);

    drain();
    repeat (100) @(posedge clk);
    if (tracker.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
